// ===== hdl/sls_pkg.sv =====
// ----------------------------------------------------------------------------
// sls_pkg
// Shared types, codes and constant tables of the sensor linearizer and
// seven-segment display driver.
// ----------------------------------------------------------------------------
package sls_pkg;

    // Request kinds carried on the input tuser
    typedef enum logic [1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_TICK   = 2'd1,
        FUNC_BUTTON = 2'd2
    } func_t;

    // Sensor modes
    typedef enum logic [1:0] {
        MODE_LIGHT = 2'd0,
        MODE_TEMP  = 2'd1,
        MODE_HUMID = 2'd2
    } mode_t;

    localparam int SAMPLE_W = 12;
    localparam int VALUE_W  = 7;
    localparam int CODE_W   = 4;
    localparam int SEG_W    = 7;
    localparam int RECIP_W  = 15;
    localparam int RECIP_SH = 18;
    localparam int PROD_W   = SAMPLE_W + RECIP_W;
    localparam int QUOT_W   = PROD_W - RECIP_SH;

    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 24;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 7'd99;
    localparam logic [CODE_W-1:0]  CODE_F    = 4'd11;

    // Light: 99 at or below LIGHT_LO, 0 at or above LIGHT_HI
    localparam logic [SAMPLE_W-1:0] LIGHT_LO = 12'd700;
    localparam logic [SAMPLE_W-1:0] LIGHT_HI = 12'd4000;
    // Humidity: 20 at or below HUMID_LO, 90 at or above HUMID_HI
    localparam logic [SAMPLE_W-1:0] HUMID_LO = 12'd600;
    localparam logic [SAMPLE_W-1:0] HUMID_HI = 12'd1900;
    localparam logic [8:0]          HUMID_BASE = 9'd85;
    // Temperature: 0 below TEMP_LO, 99 at or above TEMP_HI
    localparam logic [SAMPLE_W-1:0] TEMP_LO = 12'd1656;
    localparam logic [SAMPLE_W-1:0] TEMP_HI = 12'd3466;

    // Reciprocals ceil(2^18 / d): exact floor quotient for any 12-bit dividend
    localparam logic [RECIP_W-1:0] RECIP_33 = 15'd7944;
    localparam logic [RECIP_W-1:0] RECIP_20 = 15'd13108;

    localparam int T_SEGS = 11;
    localparam int T_SEL_W = 4;

    localparam logic [SAMPLE_W-1:0] T_BASE [T_SEGS] = '{
        12'd1656, 12'd1797, 12'd1944, 12'd2020, 12'd2102, 12'd2272,
        12'd2451, 12'd2637, 12'd2832, 12'd3035, 12'd3246
    };
    localparam logic [VALUE_W-1:0] T_OFF [T_SEGS] = '{
        7'd0, 7'd10, 7'd20, 7'd25, 7'd30, 7'd40, 7'd50, 7'd60, 7'd70, 7'd80, 7'd90
    };
    // Divisors 15,16,19,20,18,19,20,21,22,23,24 as reciprocals
    localparam logic [RECIP_W-1:0] T_RECIP [T_SEGS] = '{
        15'd17477, 15'd16384, 15'd13798, 15'd13108, 15'd14564, 15'd13798,
        15'd13108, 15'd12484, 15'd11916, 15'd11398, 15'd10923
    };

    // Pin levels per display code, low lights a segment; unused codes dark
    localparam logic [SEG_W-1:0] SEG_TABLE [16] = '{
        7'h40, 7'h6D, 7'h30, 7'h24, 7'h0D, 7'h06, 7'h02, 7'h65,
        7'h00, 7'h04, 7'h7F, 7'h13, 7'h7F, 7'h7F, 7'h7F, 7'h7F
    };

    typedef struct packed {
        func_t                 func;
        logic [SAMPLE_W-1:0]   sample;
    } item_t;

    typedef struct packed {
        logic [SEG_W-1:0]      segments;
        logic                  digit_units;
        mode_t                 mode;
        logic [VALUE_W-1:0]    value;
    } result_t;

    // Tens digit of a value 0..99 by parallel compares
    function automatic logic [CODE_W-1:0] tens_of(input logic [VALUE_W-1:0] v);
        logic [CODE_W-1:0] t;
        t = '0;
        for (int i = 1; i < 10; i++) begin
            if (v >= VALUE_W'(i * 10)) begin
                t = CODE_W'(i);
            end
        end
        return t;
    endfunction

endpackage

// ===== hdl/sensor_linearize_seven_segment_top.sv =====
// ----------------------------------------------------------------------------
// sensor_linearize_seven_segment_top
// Sensor linearizer with a two-digit seven-segment display driver.
//
//   channel  | dir | tdata                         | tuser
//   ---------+-----+-------------------------------+-------------------
//   s_axis   | in  | [11:0] sample, [15:12] zero   | [1:0] func
//   m_axis   | out | value, mode, digit, segments  | -
//
// A request passes one input register, then one result register, on its way
// to the result. One request per cycle is taken while the result side
// keeps up. The result register frees the input side while a result waits;
// a stalled result holds the request in the input register. Reset clears
// mode, digit codes and digit phase.
// ----------------------------------------------------------------------------
module sensor_linearize_seven_segment_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sls_pkg::IN_TDATA_W-1:0]   s_tdata,   // [11:0] sample
    input  logic [sls_pkg::IN_TUSER_W-1:0]   s_tuser,   // [1:0] func
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [6:0] value, [8:7] mode, [9] digit_units, [16:10] segments, [23:17] zero
    output logic [sls_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import sls_pkg::*;

    logic     in_valid_reg, in_valid_next;
    item_t    in_item_reg;
    logic     out_valid_reg, out_valid_next;
    result_t  out_res_reg;
    result_t  core_res;
    logic     s_accept;
    logic     out_load;

    // Handshake control
    assign out_load = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | out_load;
    assign s_accept = s_tvalid & s_tready;

    assign in_valid_next  = s_accept | (in_valid_reg & ~out_load);
    assign out_valid_next = out_load | (out_valid_reg & ~m_tready);

    sls_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (out_load),
        .item    (in_item_reg),
        .result  (core_res)
    );

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (s_accept) begin
            in_item_reg.func   <= func_t'(s_tuser);
            in_item_reg.sample <= s_tdata[SAMPLE_W-1:0];
        end
    end

    // Capture the result
    always_ff @(posedge clk)
    begin
        if (out_load) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - $bits(result_t))'(0), out_res_reg};

endmodule

// ===== hdl/sls_lin.sv =====
// ----------------------------------------------------------------------------
// sls_lin
// Linearizes one converter sample for the current sensor mode and clamps the
// result to 0..99. One shared reciprocal multiplier serves all modes.
// ----------------------------------------------------------------------------
module sls_lin (
    input  sls_pkg::mode_t                  mode,
    input  logic [sls_pkg::SAMPLE_W-1:0]    sample,
    output logic [sls_pkg::VALUE_W-1:0]     value
);
    import sls_pkg::*;

    logic [T_SEL_W-1:0]   seg_sel;
    logic [SAMPLE_W-1:0]  dividend;
    logic [RECIP_W-1:0]   recip;
    logic [PROD_W-1:0]    prod;
    logic [QUOT_W-1:0]    quot;
    logic [QUOT_W-1:0]    raw;

    // Find the temperature segment: highest base not above the sample
    always_comb
    begin
        seg_sel = '0;
        for (int k = 1; k < T_SEGS; k++) begin
            if (sample >= T_BASE[k]) begin
                seg_sel = T_SEL_W'(k);
            end
        end
    end

    // Pick dividend and reciprocal for the mode
    always_comb
    begin
        case (mode)
            MODE_LIGHT:
            begin
                dividend = LIGHT_HI - sample;
                recip    = RECIP_33;
            end
            MODE_TEMP:
            begin
                dividend = sample - T_BASE[seg_sel];
                recip    = T_RECIP[seg_sel];
            end
            default:
            begin
                dividend = HUMID_HI - sample;
                recip    = RECIP_20;
            end
        endcase
    end

    // Divide by constant through the reciprocal
    assign prod = PROD_W'(dividend) * PROD_W'(recip);
    assign quot = prod[PROD_W-1:RECIP_SH];

    // Apply range ends and offsets
    always_comb
    begin
        case (mode)
            MODE_LIGHT:
            begin
                if (sample >= LIGHT_HI) begin
                    raw = '0;
                end else if (sample <= LIGHT_LO) begin
                    raw = QUOT_W'(VALUE_MAX);
                end else begin
                    raw = quot;
                end
            end
            MODE_TEMP:
            begin
                if (sample < TEMP_LO) begin
                    raw = '0;
                end else if (sample >= TEMP_HI) begin
                    raw = QUOT_W'(VALUE_MAX);
                end else begin
                    raw = QUOT_W'(T_OFF[seg_sel]) + quot;
                end
            end
            default:
            begin
                if (sample >= HUMID_HI) begin
                    raw = QUOT_W'(90);
                end else if (sample <= HUMID_LO) begin
                    raw = QUOT_W'(20);
                end else begin
                    raw = HUMID_BASE - quot;
                end
            end
        endcase
    end

    // Saturate to 99
    assign value = (raw > QUOT_W'(VALUE_MAX)) ? VALUE_MAX : raw[VALUE_W-1:0];

endmodule

// ===== hdl/sls_core.sv =====
// ----------------------------------------------------------------------------
// sls_core
// Holds mode, digit codes and digit phase; works out the result of one
// request and updates the state when that request moves on.
// ----------------------------------------------------------------------------
module sls_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  sls_pkg::item_t    item,
    output sls_pkg::result_t  result
);
    import sls_pkg::*;

    mode_t              mode_reg,  mode_next;
    logic [CODE_W-1:0]  tens_reg,  tens_next;
    logic [CODE_W-1:0]  units_reg, units_next;
    logic               phase_reg, phase_next;
    logic [VALUE_W-1:0] lin_value;
    logic [CODE_W-1:0]  lin_tens;
    logic [VALUE_W-1:0] tens_times_ten;

    sls_lin u_lin (
        .mode   (mode_reg),
        .sample (item.sample),
        .value  (lin_value)
    );

    // Split the reading into display codes
    assign lin_tens       = tens_of(lin_value);
    assign tens_times_ten = {lin_tens, 3'b000} + {2'b00, lin_tens, 1'b0};

    // Decode the request
    always_comb
    begin
        mode_next          = mode_reg;
        tens_next          = tens_reg;
        units_next         = units_reg;
        phase_next         = phase_reg;
        result.value       = '0;
        result.digit_units = 1'b0;
        result.segments    = '0;
        case (item.func)
            FUNC_SAMPLE:
            begin
                result.value = lin_value;
                tens_next    = lin_tens;
                units_next   = CODE_W'(lin_value - tens_times_ten);
            end
            FUNC_TICK:
            begin
                result.digit_units = phase_reg;
                result.segments    = phase_reg ? SEG_TABLE[units_reg] : SEG_TABLE[tens_reg];
                phase_next         = ~phase_reg;
            end
            FUNC_BUTTON:
            begin
                case (mode_reg)
                    MODE_LIGHT: mode_next = MODE_TEMP;
                    MODE_TEMP:  mode_next = MODE_HUMID;
                    default:    mode_next = MODE_LIGHT;
                endcase
                tens_next  = CODE_F;
                units_next = CODE_W'(mode_next) + CODE_W'(1);
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
        result.mode = mode_next;
    end

    // Update state as the request moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_LIGHT;
            tens_reg  <= '0;
            units_reg <= '0;
            phase_reg <= 1'b0;
        end else if (advance) begin
            mode_reg  <= mode_next;
            tens_reg  <= tens_next;
            units_reg <= units_next;
            phase_reg <= phase_next;
        end
    end

endmodule

// ===== hdl/sls_checker.sv =====
// ----------------------------------------------------------------------------
// sls_checker
// Port-level checks of the sensor linearizer, bound to the top level.
// ----------------------------------------------------------------------------
module sls_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [sls_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import sls_pkg::*;

    // A stalled result stays and holds its data
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Reading saturates and mode never reaches the unused code
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[6:0] <= VALUE_MAX) && (m_tdata[8:7] != 2'd3))
        else $error("value or mode out of range");

    // A non-zero reading comes only from a sample, which drives no digit
    a_value_no_seg: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[6:0] != 7'd0) |-> (m_tdata[16:10] == 7'd0) && !m_tdata[9])
        else $error("reading and segments in one result");

    // A result appearing from empty stems from a request that passed straight through the input register
    a_rise_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without request");

endmodule

bind sensor_linearize_seven_segment_top sls_checker u_sls_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
